>>> design/ptp_pkg.sv
// ----------------------------------------------------------------------------
// Periodic timer pool package
// Shared field widths, command codes, result codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ptp_pkg;

  // Payload field widths
  localparam int CMD_W = 3;
  localparam int ID_W  = 8;
  localparam int CNT_W = 32;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_OPEN  = 3'd1,
    CMD_CLOSE = 3'd2,
    CMD_START = 3'd3,
    CMD_STOP  = 3'd4
  } cmd_t;

  // Result kind
  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  // Result status
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_TICK_RD,
    S_TICK_EX,
    S_ACK
  } state_t;

endpackage : ptp_pkg

`default_nettype wire

>>> design/periodic_timer_pool.sv
// Sequence: a command other than tick passes from decode to the ack state,
// which registers its acknowledgement; open with allocation first searches
// slots in the alloc state; a tick walks every slot through read and execute
// states and one shared count update unit fed from the count and period memories.
// Throughput: one transaction at a time; the next is taken once the ack is queued.
// Reset (synchronous): all slots idle, disabled, no handler; output empty.
// ----------------------------------------------------------------------------
// Periodic timer pool
// Pool of periodic timer slots served by a small sequencer. Commands open,
// close, start and stop slots; a tick walks every slot through one shared
// decrement/reload unit and reports expiries of slots with a handler.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_pool
  import ptp_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  wire              clk,
  input  wire              rst,
  // input channel
  input  wire              in_valid,
  output logic             in_stall,
  input  wire  [CMD_W-1:0] cmd,
  input  wire  [ID_W-1:0]  slot_id,
  input  wire  [CNT_W-1:0] period_ticks,
  input  wire              has_handler,
  // output channel
  output logic             out_valid,
  input  wire              out_stall,
  output logic             kind,
  output logic [ID_W-1:0]  slot_out,
  output logic             status,
  output logic             last
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [ID_W-1:0] NUM_SLOTS_ID = ID_W'(NUM_SLOTS);
  localparam logic [SW-1:0]   LAST_IDX     = SW'(NUM_SLOTS - 1);

  // Sequencer and slot flags
  state_t                 state, state_next;
  logic [SW-1:0]          idx, idx_next;
  logic [NUM_SLOTS-1:0]   busy, busy_next;
  logic [NUM_SLOTS-1:0]   enabled, enabled_next;
  logic [NUM_SLOTS-1:0]   has_act, has_act_next;
  logic [ID_W-1:0]        ack_slot, ack_slot_next;
  logic                   ack_status, ack_status_next;

  // Latched transaction
  cmd_t                   cur_cmd;
  logic [ID_W-1:0]        cur_id;
  logic [CNT_W-1:0]       cur_period;
  logic                   cur_handler;

  // Output register next values
  logic                   out_valid_next;
  logic                   kind_next;
  logic [ID_W-1:0]        slot_out_next;
  logic                   status_next;
  logic                   last_next;

  // Count and period memories
  logic [CNT_W-1:0]       count_mem  [NUM_SLOTS];
  logic [CNT_W-1:0]       period_mem [NUM_SLOTS];
  logic [CNT_W-1:0]       rd_count;
  logic [CNT_W-1:0]       rd_period;
  logic                   count_we;
  logic                   period_we;
  logic [SW-1:0]          mem_addr;
  logic [CNT_W-1:0]       count_wd;

  logic                   in_take;
  logic                   out_free;
  logic                   in_range;
  logic [SW-1:0]          cur_idx;
  logic                   count_zero;
  logic [CNT_W-1:0]       count_upd;
  logic                   fire_event;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_range = (cur_id < NUM_SLOTS_ID);
  assign cur_idx  = cur_id[SW-1:0];

  // Shared count update unit: reload on zero, else decrement
  assign count_zero = (rd_count == '0);
  assign count_upd  = count_zero ? rd_period : (rd_count - CNT_W'(1));
  assign fire_event = enabled[idx] && count_zero && has_act[idx];

  // Transaction capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      cur_cmd     <= cmd_t'(cmd);
      cur_id      <= slot_id;
      cur_period  <= period_ticks;
      cur_handler <= has_handler;
    end
  end

  // Memories: one write, one registered read at the walk index
  always_ff @(posedge clk) begin
    if (count_we) begin
      count_mem[mem_addr] <= count_wd;
    end
    if (period_we) begin
      period_mem[mem_addr] <= cur_period;
    end
    rd_count  <= count_mem[idx];
    rd_period <= period_mem[idx];
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      busy      <= '0;
      enabled   <= '0;
      has_act   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      busy      <= busy_next;
      enabled   <= enabled_next;
      has_act   <= has_act_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    ack_slot   <= ack_slot_next;
    ack_status <= ack_status_next;
    kind       <= kind_next;
    slot_out   <= slot_out_next;
    status     <= status_next;
    last       <= last_next;
  end

  // Sequencer: next state and datapath controls
  always_comb begin
    state_next      = state;
    idx_next        = idx;
    busy_next       = busy;
    enabled_next    = enabled;
    has_act_next    = has_act;
    ack_slot_next   = ack_slot;
    ack_status_next = ack_status;
    kind_next       = kind;
    slot_out_next   = slot_out;
    status_next     = status;
    last_next       = last;
    out_valid_next  = out_valid && out_stall;
    count_we        = 1'b0;
    period_we       = 1'b0;
    mem_addr        = idx;
    count_wd        = count_upd;

    case (state)
      S_IDLE: begin
        if (in_take) begin
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        state_next      = S_ACK;
        ack_slot_next   = cur_id;
        ack_status_next = STATUS_OK;
        case (cur_cmd)
          CMD_TICK: begin
            idx_next   = '0;
            state_next = S_TICK_RD;
          end
          CMD_OPEN: begin
            if (cur_id == '0) begin
              idx_next   = SW'(1);
              state_next = S_ALLOC;
            end else if (in_range) begin
              busy_next[cur_idx]    = 1'b1;
              enabled_next[cur_idx] = 1'b0;
              has_act_next[cur_idx] = cur_handler;
            end else begin
              ack_status_next = STATUS_FAIL;
            end
          end
          CMD_CLOSE: begin
            ack_slot_next = '0;
            if (in_range) begin
              busy_next[cur_idx]    = 1'b0;
              enabled_next[cur_idx] = 1'b0;
              has_act_next[cur_idx] = 1'b0;
            end else begin
              ack_status_next = STATUS_FAIL;
            end
          end
          CMD_START: begin
            if (in_range && (cur_id != '0)) begin
              enabled_next[cur_idx] = 1'b1;
              mem_addr              = cur_idx;
              count_wd              = cur_period;
              count_we              = 1'b1;
              period_we             = 1'b1;
            end else begin
              ack_status_next = STATUS_FAIL;
            end
          end
          CMD_STOP: begin
            if (in_range) begin
              enabled_next[cur_idx] = 1'b0;
            end else begin
              ack_status_next = STATUS_FAIL;
            end
          end
          default: begin
            ack_slot_next   = '0;
            ack_status_next = STATUS_FAIL;
          end
        endcase
      end

      // Search for the lowest idle slot from slot 1 up, one slot per cycle
      S_ALLOC: begin
        if (!busy[idx]) begin
          busy_next[idx]    = 1'b1;
          enabled_next[idx] = 1'b0;
          has_act_next[idx] = cur_handler;
          ack_slot_next     = ID_W'(idx);
          ack_status_next   = STATUS_OK;
          state_next        = S_ACK;
        end else if (idx == LAST_IDX) begin
          ack_slot_next   = '0;
          ack_status_next = STATUS_FAIL;
          state_next      = S_ACK;
        end else begin
          idx_next = idx + SW'(1);
        end
      end

      // Read data for the slot becomes valid next cycle
      S_TICK_RD: begin
        state_next = S_TICK_EX;
      end

      S_TICK_EX: begin
        if (!(fire_event && !out_free)) begin
          if (enabled[idx]) begin
            count_we = 1'b1;
          end
          if (fire_event) begin
            out_valid_next = 1'b1;
            kind_next      = KIND_EXPIRY;
            slot_out_next  = ID_W'(idx);
            status_next    = STATUS_OK;
            last_next      = 1'b0;
          end
          if (idx == LAST_IDX) begin
            ack_slot_next   = '0;
            ack_status_next = STATUS_OK;
            state_next      = S_ACK;
          end else begin
            idx_next   = idx + SW'(1);
            state_next = S_TICK_RD;
          end
        end
      end

      S_ACK: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          kind_next      = KIND_ACK;
          slot_out_next  = ack_slot;
          status_next    = ack_status;
          last_next      = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule : periodic_timer_pool

`default_nettype wire

>>> design/ptp_checker.sv
// ----------------------------------------------------------------------------
// Periodic timer pool checker
// Port-level assertions on the result stream and the input handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_checker
  import ptp_pkg::*;
(
  input wire             clk,
  input wire             rst,
  input wire             in_valid,
  input wire             in_stall,
  input wire             out_valid,
  input wire             out_stall,
  input wire             kind,
  input wire [ID_W-1:0]  slot_out,
  input wire             status,
  input wire             last
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(slot_out)
      && $stable(status) && $stable(last))
    else $error("stalled result changed");

  // One transaction at a time: busy right after acceptance
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted back to back");

  // Expiry events are never last and never fail
  a_expiry_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_EXPIRY) |-> !last && (status == STATUS_OK))
    else $error("bad expiry fields");

  // Slot 0 never expires
  a_expiry_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_EXPIRY) |-> (slot_out != '0))
    else $error("expiry on slot 0");

  // Every acknowledgement closes its transaction
  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_ACK) |-> last)
    else $error("ack without last");

endmodule : ptp_checker

bind periodic_timer_pool ptp_checker u_ptp_checker (.*);

`default_nettype wire
